// ===== rtl/core/propensity_table_event_sampler_defines.svh =====
// Assertion macros for the propensity table event sampler
`ifndef PROPENSITY_TABLE_EVENT_SAMPLER_DEFINES_SVH
`define PROPENSITY_TABLE_EVENT_SAMPLER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PTS_ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define PTS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);
`else
`define PTS_ASSERT_CLK(lbl, prop, msg)
`define PTS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/pts_pkg.sv =====
// Shared types and constants of the propensity table event sampler
`timescale 1ns / 1ps
package pts_pkg;
   localparam int ENTRIES_DEF = 1024;
   localparam int CFG_W = 11;
   localparam int WAIT_W = 48;
   localparam int LOG_W = 38;
   localparam int DIVIDEND_W = LOG_W + 16;
   localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;
   localparam logic [1:0] REQ_UPDATE = 2'd0;
   localparam logic [1:0] REQ_EVENT = 2'd1;
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [9:0]  entry_index;
      logic [31:0] new_propensity;
      logic [31:0] uniform_pick;
      logic [31:0] uniform_wait;
   } req_beat_type;

   typedef struct packed {
      logic signed [10:0] event_index;
      logic [47:0]        wait_time;
      logic [31:0]        entry_propensity;
      logic [41:0]        total_propensity;
      logic [10:0]        active_entries;
   } rsp_beat_type;
endpackage

// ===== rtl/core/pts_table.sv =====
// Propensity table memory, one write and one registered read port
`timescale 1ns / 1ps
module pts_table #(
   parameter int DEPTH = pts_pkg::ENTRIES_DEF,
   parameter int AW = $clog2(pts_pkg::ENTRIES_DEF)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [31:0]   wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [31:0]   rd_data
);
   logic [31:0] mem [DEPTH];
   logic [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/core/pts_log.sv =====
// Negative natural log of the wait fraction, Q6.32, by repeated squaring
`timescale 1ns / 1ps
module pts_log (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [31:0]                 code,
   output logic                        done,
   output logic [pts_pkg::LOG_W-1:0]   nlog
);
   localparam logic [2:0] L_IDLE = 3'd0;
   localparam logic [2:0] L_NORM = 3'd1;
   localparam logic [2:0] L_SQR  = 3'd2;
   localparam logic [2:0] L_MUL  = 3'd3;
   localparam logic [2:0] L_RND  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic [31:0] m_ff, m_in;
   logic [5:0]  e_ff, e_in;
   logic [31:0] frac_ff, frac_in;
   logic [4:0]  i_ff, i_in;
   logic [63:0] plo_ff, plo_in;
   logic [pts_pkg::LOG_W-1:0] phi_ff, phi_in;
   logic [pts_pkg::LOG_W-1:0] nlog_ff, nlog_in;
   logic        done_ff, done_in;
   logic [63:0] sq;
   logic [32:0] t;
   logic [pts_pkg::LOG_W-1:0] nl;
   logic [63:0] rnd;

   assign sq  = 64'(m_ff) * 64'(m_ff);
   assign t   = sq[63:31];
   assign nl  = {6'd32, 32'd0} - {e_ff, frac_ff};
   assign rnd = plo_ff + 64'h8000_0000;

   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      e_in     = e_ff;
      frac_in  = frac_ff;
      i_in     = i_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      nlog_in  = nlog_ff;
      done_in  = 1'b0;
      unique case (state_ff)
         L_IDLE: begin
            if (start) begin
               frac_in = '0;
               i_in    = 5'd31;
               if (&code) begin
                  m_in     = 32'h8000_0000;
                  e_in     = 6'd32;
                  state_in = L_SQR;
               end else begin
                  m_in     = code + 32'd1;
                  e_in     = 6'd31;
                  state_in = L_NORM;
               end
            end
         end
         L_NORM: begin
            if (m_ff[31]) begin
               state_in = L_SQR;
            end else begin
               m_in = {m_ff[30:0], 1'b0};
               e_in = e_ff - 6'd1;
            end
         end
         L_SQR: begin
            if (t[32]) begin
               m_in          = t[32:1];
               frac_in[i_ff] = 1'b1;
            end else begin
               m_in = t[31:0];
            end
            if (i_ff == 5'd0) begin
               state_in = L_MUL;
            end else begin
               i_in = i_ff - 5'd1;
            end
         end
         L_MUL: begin
            plo_in   = 64'(nl[31:0]) * 64'(pts_pkg::LN2_Q32);
            phi_in   = pts_pkg::LOG_W'(nl[37:32]) * pts_pkg::LOG_W'(pts_pkg::LN2_Q32);
            state_in = L_RND;
         end
         L_RND: begin
            nlog_in  = phi_ff + pts_pkg::LOG_W'(rnd[63:32]);
            done_in  = 1'b1;
            state_in = L_IDLE;
         end
         default: state_in = L_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      m_ff    <= m_in;
      e_ff    <= e_in;
      frac_ff <= frac_in;
      i_ff    <= i_in;
      plo_ff  <= plo_in;
      phi_ff  <= phi_in;
      nlog_ff <= nlog_in;
   end

   assign done = done_ff;
   assign nlog = nlog_ff;
endmodule

// ===== rtl/core/pts_div.sv =====
// Restoring divider, one quotient bit a cycle
`timescale 1ns / 1ps
module pts_div #(
   parameter int SUM_W = 32 + $clog2(pts_pkg::ENTRIES_DEF + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [pts_pkg::DIVIDEND_W-1:0]  dividend,
   input  logic [SUM_W-1:0]                divisor,
   output logic                            done,
   output logic [pts_pkg::DIVIDEND_W-1:0]  quotient
);
   localparam int DW = pts_pkg::DIVIDEND_W;
   localparam int CNTW = $clog2(DW);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic [SUM_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0] dvs_ff, dvs_in;
   logic [DW-1:0]   quo_ff, quo_in;
   logic [SUM_W:0]  r2;
   logic            ge;

   assign r2 = {rem_ff, quo_ff[DW-1]};
   assign ge = r2 >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (busy_ff) begin
         rem_in = ge ? SUM_W'(r2 - {1'b0, dvs_ff}) : SUM_W'(r2);
         quo_in = {quo_ff[DW-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - CNTW'(1);
         end
      end else if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNTW'(DW - 1);
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ===== rtl/core/propensity_table_event_sampler.sv =====
// Top level of the propensity table event sampler
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | req_data (req_beat_type)
//  rsp     | out       | rsp_valid/rsp_ready  | rsp_data (rsp_beat_type)
//  csr     | in        | csr_wr_en            | csr_wr_data (entries in use)
//
//  One beat at a time. Update and read: the lookup state, then the done state, which
//  registers rsp_valid. Event with entries active: lookup, multiply, threshold, then
//  the scan reads one table entry a cycle up to n, the entries in use, while the log
//  and divider run beside it. After reset the table is cleared, one entry a cycle, with
//  req_ready low. A result waiting on rsp_ready holds the next beat in its final step.
`timescale 1ns / 1ps
`include "propensity_table_event_sampler_defines.svh"
module propensity_table_event_sampler #(
   parameter int ENTRIES = pts_pkg::ENTRIES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  pts_pkg::req_beat_type       req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output pts_pkg::rsp_beat_type       rsp_data,
   input  logic                        csr_wr_en,
   input  logic [pts_pkg::CFG_W-1:0]   csr_wr_data
);
   localparam int AW = $clog2(ENTRIES);
   localparam int CW = $clog2(ENTRIES + 1);
   localparam int SW = 32 + CW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOOK = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_THR  = 3'd3;
   localparam logic [2:0] ST_SCAN = 3'd4;
   localparam logic [2:0] ST_DONE = 3'd5;

   logic [2:0]  state_ff, state_in;
   pts_pkg::req_beat_type req_ff, req_in;
   logic [pts_pkg::CFG_W-1:0] cfg_ff, cfg_in;
   logic [SW-1:0] sum_ff, sum_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [31:0] old_ff, old_in;
   logic [10:0] ev_ff, ev_in;
   logic [pts_pkg::WAIT_W-1:0] wait_ff, wait_in;
   logic        wait_ok_ff, wait_ok_in;
   logic [63:0] plo_ff, plo_in;
   logic [SW-1:0] phi_ff, phi_in;
   logic [SW-1:0] thr_ff, thr_in;
   logic [SW-1:0] part_ff, part_in;
   logic [AW-1:0] scan_addr_ff, scan_addr_in;
   logic [AW-1:0] chk_k_ff, chk_k_in;
   logic        chk_valid_ff, chk_valid_in;
   logic        issue_on_ff, issue_on_in;
   logic        clr_on_ff, clr_on_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;
   logic        rsp_valid_ff, rsp_valid_in;
   pts_pkg::rsp_beat_type rsp_ff, rsp_in;

   logic          idx_ok;
   logic [31:0]   rd_data;
   logic [31:0]   old_w;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic [AW-1:0] last_w;
   logic [SW-1:0] part_nx;
   logic          log_start;
   logic          log_done;
   logic [pts_pkg::LOG_W-1:0] nlog;
   logic          div_done;
   logic [pts_pkg::DIVIDEND_W-1:0] quo;

   assign idx_ok  = 32'(req_ff.entry_index) < 32'(ENTRIES);
   assign old_w   = idx_ok ? rd_data : 32'd0;
   assign part_nx = part_ff + SW'(rd_data);
   assign rd_addr = (state_ff == ST_SCAN) ? scan_addr_ff : AW'(req_data.entry_index);
   assign wr_en   = clr_on_ff ||
                    (state_ff == ST_LOOK && req_ff.req_type == pts_pkg::REQ_UPDATE && idx_ok);
   assign wr_addr = clr_on_ff ? clr_addr_ff : AW'(req_ff.entry_index);
   assign wr_data = clr_on_ff ? 32'd0 : req_ff.new_propensity;
   assign log_start = state_ff == ST_LOOK && req_ff.req_type == pts_pkg::REQ_EVENT &&
                      cnt_ff != '0;

   always_comb begin
      int n_int;
      n_int = int'(cfg_ff);
      if (n_int == 0) begin
         n_int = 1;
      end
      if (n_int > ENTRIES) begin
         n_int = ENTRIES;
      end
      last_w = AW'(n_int - 1);
   end

   pts_table #(.DEPTH(ENTRIES), .AW(AW)) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pts_log u_log (
      .clock (clock),
      .reset (reset),
      .start (log_start),
      .code  (req_ff.uniform_wait),
      .done  (log_done),
      .nlog  (nlog)
   );

   pts_div #(.SUM_W(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (log_done),
      .dividend ({nlog, 16'd0}),
      .divisor  (sum_ff),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cfg_in       = csr_wr_en ? csr_wr_data : cfg_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      old_in       = old_ff;
      ev_in        = ev_ff;
      wait_in      = wait_ff;
      wait_ok_in   = wait_ok_ff;
      plo_in       = plo_ff;
      phi_in       = phi_ff;
      thr_in       = thr_ff;
      part_in      = part_ff;
      scan_addr_in = scan_addr_ff;
      chk_k_in     = chk_k_ff;
      chk_valid_in = chk_valid_ff;
      issue_on_in  = issue_on_ff;
      clr_on_in    = clr_on_ff;
      clr_addr_in  = clr_addr_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (clr_on_ff) begin
         if (clr_addr_ff == AW'(ENTRIES - 1)) begin
            clr_on_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + AW'(1);
         end
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (div_done) begin
         wait_in    = (|quo[pts_pkg::DIVIDEND_W-1:pts_pkg::WAIT_W]) ? '1 :
                      quo[pts_pkg::WAIT_W-1:0];
         wait_ok_in = 1'b1;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               req_in   = req_data;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            old_in     = old_w;
            ev_in      = '0;
            wait_in    = '0;
            wait_ok_in = 1'b1;
            state_in   = ST_DONE;
            case (req_ff.req_type)
               pts_pkg::REQ_UPDATE: begin
                  if (idx_ok) begin
                     sum_in = sum_ff - SW'(old_w) + SW'(req_ff.new_propensity);
                     cnt_in = cnt_ff - CW'(old_w != 32'd0) +
                              CW'(req_ff.new_propensity != 32'd0);
                  end
               end
               pts_pkg::REQ_EVENT: begin
                  if (cnt_ff == '0) begin
                     sum_in = '0;
                     ev_in  = '1;
                  end else begin
                     wait_ok_in = 1'b0;
                     state_in   = ST_MUL;
                  end
               end
               default: ;
            endcase
         end
         ST_MUL: begin
            plo_in   = 64'(sum_ff[31:0]) * 64'(req_ff.uniform_pick);
            phi_in   = SW'(sum_ff[SW-1:32]) * SW'(req_ff.uniform_pick);
            state_in = ST_THR;
         end
         ST_THR: begin
            thr_in       = phi_ff + SW'(plo_ff[63:32]);
            part_in      = '0;
            scan_addr_in = '0;
            chk_valid_in = 1'b0;
            issue_on_in  = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            chk_valid_in = issue_on_ff;
            if (issue_on_ff) begin
               chk_k_in = scan_addr_ff;
               if (scan_addr_ff == last_w) begin
                  issue_on_in = 1'b0;
               end else begin
                  scan_addr_in = scan_addr_ff + AW'(1);
               end
            end
            if (chk_valid_ff) begin
               part_in = part_nx;
               if (part_nx > thr_ff || chk_k_ff == last_w) begin
                  ev_in        = 11'(chk_k_ff);
                  issue_on_in  = 1'b0;
                  chk_valid_in = 1'b0;
                  state_in     = ST_DONE;
               end
            end
         end
         ST_DONE: begin
            if (wait_ok_ff && (!rsp_valid_ff || rsp_ready)) begin
               rsp_valid_in              = 1'b1;
               rsp_in.event_index        = ev_ff;
               rsp_in.wait_time          = wait_ff;
               rsp_in.entry_propensity   = old_ff;
               rsp_in.total_propensity   = 42'(sum_ff);
               rsp_in.active_entries     = 11'(cnt_ff);
               state_in                  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cfg_ff       <= pts_pkg::CFG_RESET;
         sum_ff       <= '0;
         cnt_ff       <= '0;
         wait_ok_ff   <= 1'b1;
         chk_valid_ff <= 1'b0;
         issue_on_ff  <= 1'b0;
         clr_on_ff    <= 1'b1;
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
         sum_ff       <= sum_in;
         cnt_ff       <= cnt_in;
         wait_ok_ff   <= wait_ok_in;
         chk_valid_ff <= chk_valid_in;
         issue_on_ff  <= issue_on_in;
         clr_on_ff    <= clr_on_in;
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff       <= req_in;
      old_ff       <= old_in;
      ev_ff        <= ev_in;
      wait_ff      <= wait_in;
      plo_ff       <= plo_in;
      phi_ff       <= phi_in;
      thr_ff       <= thr_in;
      part_ff      <= part_in;
      scan_addr_ff <= scan_addr_in;
      chk_k_ff     <= chk_k_in;
      rsp_ff       <= rsp_in;
   end

   assign req_ready = state_ff == ST_IDLE && !clr_on_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `PTS_ASSERT_ALWAYS(a_no_accept_clear, clr_on_ff |-> !req_ready, "beat taken during clear")
   `PTS_ASSERT_CLK(a_count_bound, cnt_ff <= CW'(ENTRIES), "active count beyond table")
   `PTS_ASSERT_CLK(a_zero_count_sum, (cnt_ff == '0) |-> (sum_ff == '0), "sum without entries")
   `PTS_ASSERT_CLK(a_accept_look, (req_valid && req_ready) |=> (state_ff == ST_LOOK), "no lookup")
endmodule

// ===== sim/propensity_table_event_sampler_test.sv =====
// Self-checking testbench for the propensity table event sampler
`timescale 1ns / 1ps
module propensity_table_event_sampler_test;
   localparam int TABLE_DEPTH = 1024;
   localparam logic [1:0] REQ_READ = 2'd2;
   localparam logic [1:0] REQ_ODD = 2'd3;
   localparam logic [63:0] MASK48 = (64'd1 << 48) - 64'd1;
   localparam int CYCLE_LIMIT = 3000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pts_pkg::req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pts_pkg::rsp_beat_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [pts_pkg::CFG_W-1:0] csr_wr_data = '0;

   logic [31:0] shadow_table [TABLE_DEPTH];
   logic [63:0] shadow_sum;
   int unsigned shadow_active;
   logic [pts_pkg::CFG_W-1:0] shadow_in_use;
   pts_pkg::rsp_beat_type pending_results[$];

   int errors = 0;
   int cycles = 0;
   int burst_left = 0;
   int hold_cycles = 0;
   int pat_age = 0;
   logic [15:0] stall_pat = 16'hFFFF;

   propensity_table_event_sampler dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // -ln((code+1)/2^32) in Q6.32
   function automatic logic [63:0] neg_log_q32(logic [31:0] code);
      logic [63:0] x, m, lg, nl, hi, lo;
      int e;
      x = {32'd0, code} + 64'd1;
      e = 0;
      while (e < 32 && (x >> (e + 1)) != 0) e++;
      if (e > 31) m = x >> (e - 31);
      else m = x << (31 - e);
      lg = 64'(e) << 32;
      for (int i = 31; i >= 0; i--) begin
         m = (m * m) >> 31;
         if (m >= (64'd1 << 32)) begin
            m = m >> 1;
            lg[i] = 1'b1;
         end
      end
      nl = (64'd32 << 32) - lg;
      hi = nl >> 32;
      lo = {32'd0, nl[31:0]};
      return hi * pts_pkg::LN2_Q32 + ((lo * pts_pkg::LN2_Q32 + (64'd1 << 31)) >> 32);
   endfunction

   function automatic void predict_beat(pts_pkg::req_beat_type b);
      pts_pkg::rsp_beat_type r;
      logic [31:0] prior;
      logic [63:0] thr, part, lnv, q;
      int n, k;
      r = '0;
      prior = shadow_table[b.entry_index];
      if (b.req_type == pts_pkg::REQ_UPDATE) begin
         if (prior != 0) shadow_active--;
         if (b.new_propensity != 0) shadow_active++;
         shadow_sum = shadow_sum - prior + b.new_propensity;
         shadow_table[b.entry_index] = b.new_propensity;
      end else if (b.req_type == pts_pkg::REQ_EVENT) begin
         if (shadow_active == 0) begin
            shadow_sum = 0;
            r.event_index = -11'sd1;
         end else begin
            n = shadow_in_use;
            if (n == 0) n = 1;
            if (n > TABLE_DEPTH) n = TABLE_DEPTH;
            thr = (shadow_sum >> 32) * b.uniform_pick +
                  (({32'd0, shadow_sum[31:0]} * b.uniform_pick) >> 32);
            part = 0;
            for (k = 0; k < n; k++) begin
               part += shadow_table[k];
               if (part > thr) break;
            end
            if (k >= n) k = n - 1;
            r.event_index = 11'(k);
            lnv = neg_log_q32(b.uniform_wait);
            if (shadow_sum == 0) r.wait_time = MASK48[47:0];
            else begin
               q = (lnv << 16) / shadow_sum;
               r.wait_time = (q > MASK48) ? MASK48[47:0] : q[47:0];
            end
         end
      end
      r.entry_propensity = prior;
      r.total_propensity = shadow_sum[41:0];
      r.active_entries = 11'(shadow_active);
      pending_results.push_back(r);
   endfunction

   always @(posedge clock) begin
      pts_pkg::rsp_beat_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected beat, actual %p", $time, rsp_data);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (e.event_index !== rsp_data.event_index ||
                e.wait_time !== rsp_data.wait_time ||
                e.entry_propensity !== rsp_data.entry_propensity ||
                e.total_propensity !== rsp_data.total_propensity ||
                e.active_entries !== rsp_data.active_entries) begin
               $display("%0t: mismatch, expected %p actual %p", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         pat_age <= pat_age + 1;
         if (pat_age % 64 == 63)
            stall_pat <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : (16'($urandom) | 16'h1);
         else
            stall_pat <= {stall_pat[0], stall_pat[15:1]};
         rsp_ready <= stall_pat[0];
      end
   end

   task automatic send_beat(pts_pkg::req_beat_type b);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data <= b;
      do @(posedge clock); while (!req_ready);
      predict_beat(b);
      if (burst_left > 0) burst_left--;
      else begin
         burst_left = $urandom_range(0, 3) == 0 ? 30 : $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat ($urandom_range(0, 7)) @(negedge clock);
      end
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_in_use(logic [pts_pkg::CFG_W-1:0] v);
      drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      shadow_in_use = v;
   endtask

   function automatic pts_pkg::req_beat_type make_beat(logic [1:0] t, logic [9:0] idx,
                                                       logic [31:0] v, logic [31:0] p,
                                                       logic [31:0] w);
      pts_pkg::req_beat_type b;
      b.req_type = t;
      b.entry_index = idx;
      b.new_propensity = v;
      b.uniform_pick = p;
      b.uniform_wait = w;
      return b;
   endfunction

   task automatic test_empty_table;
      send_beat(make_beat(REQ_READ, 10'd0, 32'd5, 32'd0, 32'd0));
      send_beat(make_beat(REQ_READ, 10'd1023, 32'd0, 32'd0, 32'd0));
      send_beat(make_beat(pts_pkg::REQ_EVENT, 10'd0, 32'd0, 32'hFFFFFFFF, 32'd7));
   endtask

   task automatic test_directed;
      send_beat(make_beat(pts_pkg::REQ_UPDATE, 10'd0, 32'hFFFFFFFF, 32'd0, 32'd0));
      send_beat(make_beat(pts_pkg::REQ_UPDATE, 10'd1023, 32'h00010000, 32'd0, 32'd0));
      send_beat(make_beat(pts_pkg::REQ_UPDATE, 10'd5, 32'd1, 32'd0, 32'd0));
      send_beat(make_beat(REQ_ODD, 10'd5, 32'd9, 32'd0, 32'd0));
      send_beat(make_beat(pts_pkg::REQ_EVENT, 10'd0, 32'd0, 32'd0, 32'd0));
      send_beat(make_beat(pts_pkg::REQ_EVENT, 10'd0, 32'd0, 32'hFFFFFFFF, 32'hFFFFFFFF));
      send_beat(make_beat(pts_pkg::REQ_EVENT, 10'd0, 32'd0, 32'hFFFFFFF0, 32'h80000000));
      write_in_use(11'd1);
      send_beat(make_beat(pts_pkg::REQ_EVENT, 10'd0, 32'd0, 32'hFFFFFFFF, 32'd1));
      write_in_use(11'd0);
      send_beat(make_beat(pts_pkg::REQ_EVENT, 10'd0, 32'd0, 32'h7FFFFFFF, 32'd100));
      write_in_use(11'd2047);
      send_beat(make_beat(pts_pkg::REQ_EVENT, 10'd0, 32'd0, 32'hFFFFFFFF, 32'd12345));
      send_beat(make_beat(pts_pkg::REQ_UPDATE, 10'd0, 32'd0, 32'd0, 32'd0));
      send_beat(make_beat(pts_pkg::REQ_UPDATE, 10'd5, 32'd0, 32'd0, 32'd0));
      send_beat(make_beat(pts_pkg::REQ_UPDATE, 10'd1023, 32'd0, 32'd0, 32'd0));
      send_beat(make_beat(pts_pkg::REQ_EVENT, 10'd0, 32'd0, 32'h12345678, 32'd3));
      send_beat(make_beat(REQ_READ, 10'd1023, 32'd0, 32'd0, 32'd0));
   endtask

   task automatic test_random_phase(int count, int span);
      pts_pkg::req_beat_type b;
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(0, 99);
         b = make_beat(REQ_READ, 10'($urandom_range(0, span - 1)), $urandom, $urandom,
                       $urandom);
         if ($urandom_range(0, 9) == 0) b.entry_index = 10'($urandom);
         if (sel < 42) begin
            b.req_type = pts_pkg::REQ_UPDATE;
            case ($urandom_range(0, 3))
               0: b.new_propensity = 32'd0;
               1: b.new_propensity = 32'($urandom_range(1, 32'h0003FFFF));
               default: ;
            endcase
         end else if (sel < 77) b.req_type = pts_pkg::REQ_EVENT;
         else if (sel < 95) b.req_type = REQ_READ;
         else b.req_type = REQ_ODD;
         send_beat(b);
      end
   endtask

   task automatic test_random;
      int span;
      for (int ph = 0; ph < 10; ph++) begin
         span = (ph == 9) ? TABLE_DEPTH : $urandom_range(1, 64);
         write_in_use((ph == 9) ? 11'd1024 : 11'($urandom_range(1, span)));
         test_random_phase((ph == 9) ? 20 : 50, span);
      end
   endtask

   task automatic test_backpressure;
      drain();
      write_in_use(11'd16);
      hold_cycles = 400;
      burst_left = 40;
      for (int i = 0; i < 12; i++)
         send_beat(make_beat(REQ_READ, 10'($urandom_range(0, 15)), 32'd0, 32'd0, 32'd0));
      test_random_phase(10, 16);
   endtask

   initial begin
      foreach (shadow_table[i]) shadow_table[i] = '0;
      shadow_sum = 0;
      shadow_active = 0;
      shadow_in_use = pts_pkg::CFG_RESET;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_directed();
      test_backpressure();
      test_random();
      drain();
      repeat (200) @(posedge clock);
      if (errors == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end
endmodule
